// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: design/sblm_pkg.sv
// ----------------------------------------------------------------------------
// sblm_pkg
// Shared types and constants of the stylus button layer mapper.
// ----------------------------------------------------------------------------
package sblm_pkg;

    // field widths
    localparam int SLOT_W  = 4;
    localparam int SLOTS   = 2 ** SLOT_W;
    localparam int VB_W    = 7;
    localparam int MV_W    = 4;
    localparam int NCOMP_W = 4;
    localparam int NMOD_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COMPONENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_MODIFIERS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_MODE     = 2'd2;

    typedef struct packed {
        logic [NCOMP_W-1:0] num_components;
        logic [NMOD_W-1:0]  num_modifiers;
        logic               chord_mode;
    } t_cfg;

    typedef struct packed {
        logic [SLOT_W-1:0] component;
        logic [MV_W-1:0]   modifier_value;
        logic [SLOTS-1:0]  slot_bits;
    } t_state;

    typedef struct packed {
        logic [VB_W-1:0] virtual_button;
        logic            virtual_pressed;
        logic            last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        t_state     next_state;
    } t_eval;

endpackage

// File: design/sblm_eval.sv
// ----------------------------------------------------------------------------
// sblm_eval
// Evaluates one button event against the held state: the results it causes
// and the state it leaves behind.
// ----------------------------------------------------------------------------
module sblm_eval
    import sblm_pkg::*;
#(
    parameter int MAX_COMPONENTS = 8,
    parameter int MAX_MODIFIERS  = 4
) (
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_press,
    output t_eval             o_eval
);

    localparam logic [SLOT_W:0] MaxComp = (SLOT_W+1)'(MAX_COMPONENTS);
    localparam logic [NMOD_W-1:0] MaxMod = NMOD_W'(MAX_MODIFIERS);

    // virtual index of a component / modifier pair, kept to 7 bits
    function automatic logic [VB_W-1:0] f_index(
        input logic [SLOT_W-1:0] comp,
        input logic [MV_W-1:0]   mv,
        input logic              chord,
        input logic [NMOD_W-1:0] nm
    );
        logic [VB_W-1:0] base;
        if (chord) begin
            base = VB_W'(comp) << nm;
        end else begin
            base = VB_W'(VB_W'(comp) * (VB_W'(nm) + VB_W'(1)));
        end
        return base + VB_W'(mv);
    endfunction

    logic [SLOT_W-1:0] nc;
    logic [NMOD_W-1:0] nm;
    logic [SLOT_W:0]   limit;
    logic [SLOTS-1:0]  bits_new;
    logic              touch_st;
    logic [SLOT_W-1:0] mdiff;
    logic [NMOD_W-1:0] midx;
    logic [7:0]        onehot;
    logic [MV_W-1:0]   mv_rel;
    logic [MV_W-1:0]   mv_next;
    logic [SLOT_W:0]   pos;
    logic [VB_W-1:0]   old_idx;

    always_comb begin
        // clamp the layout registers
        if (i_cfg.num_components == '0) begin
            nc = SLOT_W'(1);
        end else if ({1'b0, i_cfg.num_components} > MaxComp) begin
            nc = MaxComp[SLOT_W-1:0];
        end else begin
            nc = i_cfg.num_components;
        end
        nm = (i_cfg.num_modifiers > MaxMod) ? MaxMod : i_cfg.num_modifiers;
        limit = (SLOT_W+1)'(nc) + (SLOT_W+1)'(nm) + (SLOT_W+1)'(1);

        // slot state after this event
        if (i_press) begin
            bits_new = i_state.slot_bits | (SLOTS'(1) << i_slot);
        end else begin
            bits_new = i_state.slot_bits & ~(SLOTS'(1) << i_slot);
        end
        touch_st = bits_new[nc];
        old_idx  = f_index(i_state.component, i_state.modifier_value,
                           i_cfg.chord_mode, nm);

        // modifier number within the modifier group
        mdiff  = i_slot - nc - SLOT_W'(1);
        midx   = mdiff[NMOD_W-1:0];
        onehot = 8'd1 << midx;

        // lowest other pressed modifier, for a release outside chord mode
        mv_rel = '0;
        pos    = '0;
        for (int i = MAX_MODIFIERS - 1; i >= 0; i--) begin
            pos = (SLOT_W+1)'(nc) + (SLOT_W+1)'(1) + (SLOT_W+1)'(i);
            if (NMOD_W'(i) < nm && pos != {1'b0, i_slot} && !pos[SLOT_W]
                && bits_new[pos[SLOT_W-1:0]]) begin
                mv_rel = MV_W'(i + 1);
            end
        end

        // new modifier value
        if (i_cfg.chord_mode) begin
            if (i_press) begin
                mv_next = i_state.modifier_value | onehot[MV_W-1:0];
            end else begin
                mv_next = i_state.modifier_value & ~onehot[MV_W-1:0];
            end
        end else if (i_press) begin
            if (i_state.modifier_value == '0
                || i_state.modifier_value > (MV_W'(midx) + MV_W'(1))) begin
                mv_next = MV_W'(midx) + MV_W'(1);
            end else begin
                mv_next = i_state.modifier_value;
            end
        end else begin
            mv_next = mv_rel;
        end

        // results and next state by slot kind
        o_eval.count      = 2'd0;
        o_eval.res0       = '{virtual_button: old_idx, virtual_pressed: 1'b0,
                              last_of_run: 1'b0};
        o_eval.res1       = '0;
        o_eval.next_state = i_state;
        if ({1'b0, i_slot} < limit) begin
            o_eval.next_state.slot_bits = bits_new;
            if (i_slot < nc) begin
                if (i_press) begin
                    o_eval.count = 2'd2;
                    o_eval.next_state.component = i_slot;
                    o_eval.res1 = '{
                        virtual_button:  f_index(i_slot, i_state.modifier_value,
                                                 i_cfg.chord_mode, nm),
                        virtual_pressed: touch_st,
                        last_of_run:     1'b1};
                end
            end else if (i_slot == nc) begin
                o_eval.count = 2'd1;
                o_eval.res0  = '{virtual_button: old_idx, virtual_pressed: i_press,
                                 last_of_run: 1'b1};
            end else begin
                o_eval.count = 2'd2;
                o_eval.next_state.modifier_value = mv_next;
                o_eval.res1 = '{
                    virtual_button:  f_index(i_state.component, mv_next,
                                             i_cfg.chord_mode, nm),
                    virtual_pressed: touch_st,
                    last_of_run:     1'b1};
            end
        end
    end

endmodule

// File: design/stylus_button_layer_mapper.sv
// ----------------------------------------------------------------------------
// stylus_button_layer_mapper
// Maps physical stylus button events onto a bank of virtual buttons.
// ----------------------------------------------------------------------------
// An event is taken into an input register, evaluated in the next cycle and
// its results placed in a result register, from which they leave one per
// cycle while the output is not stalled. Events that cause no result or one
// result sustain one event per cycle while the output is not stalled; events
// that cause two results (selector press, modifier event) leave the input
// register only once the single result register is empty or sends its last
// result. A new event is taken while results still wait. Configuration writes
// are always ready and are meant for an idle block.
module stylus_button_layer_mapper
    import sblm_pkg::*;
#(
    parameter int MAX_COMPONENTS = 8,
    parameter int MAX_MODIFIERS  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event input
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SLOT_W-1:0]     i_button_slot,
    input  logic                  i_pressed,
    // result output
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VB_W-1:0]       o_virtual_button,
    output logic                  o_virtual_pressed,
    output logic                  o_last_of_run,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    t_cfg              r_cfg, n_cfg;
    t_state            r_state, n_state;
    logic              r_in_valid, n_in_valid;
    logic [SLOT_W-1:0] r_in_slot, n_in_slot;
    logic              r_in_press, n_in_press;
    logic              r_pair_valid, n_pair_valid;
    logic              r_two, n_two;
    logic              r_sel, n_sel;
    t_result           r_res0, n_res0;
    t_result           r_res1, n_res1;

    t_eval   eval;
    t_result cur;
    logic    pair_done;
    logic    pair_free;
    logic    in_move;
    logic    in_push;
    logic    in_take;

    // event evaluation
    sblm_eval #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .MAX_MODIFIERS  (MAX_MODIFIERS)
    ) u_eval (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_slot  (r_in_slot),
        .i_press (r_in_press),
        .o_eval  (eval)
    );

    // handshake control
    assign pair_done = r_pair_valid && !i_stall && (r_sel || !r_two);
    assign pair_free = !r_pair_valid || pair_done;
    assign in_move   = r_in_valid && (eval.count == 2'd0 || pair_free);
    assign in_push   = in_move && eval.count != 2'd0;
    assign o_stall   = r_in_valid && !in_move;
    assign in_take   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // result output
    assign cur               = r_sel ? r_res1 : r_res0;
    assign o_valid           = r_pair_valid;
    assign o_virtual_button  = cur.virtual_button;
    assign o_virtual_pressed = cur.virtual_pressed;
    assign o_last_of_run     = cur.last_of_run;

    // next-state logic
    always_comb begin
        n_cfg        = r_cfg;
        n_state      = r_state;
        n_in_valid   = r_in_valid;
        n_in_slot    = r_in_slot;
        n_in_press   = r_in_press;
        n_pair_valid = r_pair_valid;
        n_two        = r_two;
        n_sel        = r_sel;
        n_res0       = r_res0;
        n_res1       = r_res1;

        // configuration register writes
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_COMPONENTS: n_cfg.num_components = i_cfg_data[NCOMP_W-1:0];
                CFG_NUM_MODIFIERS:  n_cfg.num_modifiers  = i_cfg_data[NMOD_W-1:0];
                CFG_CHORD_MODE:     n_cfg.chord_mode     = i_cfg_data[0];
                default: ;
            endcase
        end

        // input register
        if (in_take) begin
            n_in_valid = 1'b1;
            n_in_slot  = i_button_slot;
            n_in_press = i_pressed;
        end else if (in_move) begin
            n_in_valid = 1'b0;
        end

        // commit the event's state change
        if (in_move) begin
            n_state = eval.next_state;
        end

        // result register
        if (in_push) begin
            n_pair_valid = 1'b1;
            n_two        = (eval.count == 2'd2);
            n_sel        = 1'b0;
            n_res0       = eval.res0;
            n_res1       = eval.res1;
        end else if (pair_done) begin
            n_pair_valid = 1'b0;
            n_sel        = 1'b0;
        end else if (r_pair_valid && !i_stall) begin
            n_sel = 1'b1;
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= '{num_components: NCOMP_W'(1), num_modifiers: '0,
                              chord_mode: 1'b0};
            r_state      <= '0;
            r_in_valid   <= 1'b0;
            r_pair_valid <= 1'b0;
            r_two        <= 1'b0;
            r_sel        <= 1'b0;
        end else begin
            r_cfg        <= n_cfg;
            r_state      <= n_state;
            r_in_valid   <= n_in_valid;
            r_pair_valid <= n_pair_valid;
            r_two        <= n_two;
            r_sel        <= n_sel;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in_slot  <= n_in_slot;
        r_in_press <= n_in_press;
        r_res0     <= n_res0;
        r_res1     <= n_res1;
    end

    // checks
    `ASSERT_NEVER(a_sel_needs_two, i_clk, i_rst_n, r_pair_valid && r_sel && !r_two, "second result selected for a one-result event")
    `ASSERT_CLK(a_stall_needs_item, i_clk, i_rst_n, o_stall |-> r_in_valid, "input stalled with an empty input register")
    `ASSERT_CLK(a_second_follows, i_clk, i_rst_n, (o_valid && !i_stall && !o_last_of_run) |=> (o_valid && o_last_of_run), "first result not followed by the last one")
    `ASSERT_CLK(a_drain_empties, i_clk, i_rst_n, (pair_done && !in_push) |=> !o_valid, "result register not emptied after its last result")

endmodule

// File: tb/sv/stylus_button_layer_mapper_test.sv
// ----------------------------------------------------------------------------
// stylus_button_layer_mapper_test
// Self-checking bench for the stylus button layer mapper. Button items go in
// on a valid/stall channel and are mirrored by a behavioral layer model. The
// virtual button items that come out are compared against that model in order.
// Directed tests cover the layout extremes, modifier priority, chord masks,
// register clamping and stale state. Random phases follow with varied layouts
// and random idling on both sides.
// ----------------------------------------------------------------------------
module stylus_button_layer_mapper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sblm_pkg::*;

    localparam int COMPONENTS_MAX  = 8;
    localparam int MODIFIERS_MAX   = 4;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int REPORT_LIMIT    = 10;
    localparam longint TIMEOUT_NS  = 2_000_000;

    // register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [SLOT_W-1:0]     i_button_slot = '0;
    logic                  i_pressed = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [VB_W-1:0]       o_virtual_button;
    logic                  o_virtual_pressed;
    logic                  o_last_of_run;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // layout registers and state of the behavioral model
    logic [NCOMP_W-1:0] lay_num_components;
    logic [NMOD_W-1:0]  lay_num_modifiers;
    logic               lay_chord;
    int unsigned        cur_component;
    logic [MV_W-1:0]    cur_modifier;
    logic [SLOTS-1:0]   held_slots;

    t_result pending_vbuttons[$];

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int failures = 0;
    int items_sent = 0;
    int items_ignored = 0;
    int results_seen = 0;
    int cfg_writes = 0;

    stylus_button_layer_mapper #(
        .MAX_COMPONENTS(COMPONENTS_MAX),
        .MAX_MODIFIERS (MODIFIERS_MAX)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_button_slot    (i_button_slot),
        .i_pressed        (i_pressed),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_virtual_button (o_virtual_button),
        .o_virtual_pressed(o_virtual_pressed),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // random receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // layout helpers of the model
    function automatic int unsigned comps_in_use();
        if (lay_num_components == 0) return 1;
        if (lay_num_components > COMPONENTS_MAX) return COMPONENTS_MAX;
        return 32'(lay_num_components);
    endfunction

    function automatic int unsigned mods_in_use();
        if (lay_num_modifiers > MODIFIERS_MAX) return MODIFIERS_MAX;
        return 32'(lay_num_modifiers);
    endfunction

    function automatic int unsigned layout_slots();
        return comps_in_use() + 1 + mods_in_use();
    endfunction

    function automatic logic [VB_W-1:0] active_vbutton();
        int unsigned per_comp;
        int unsigned idx;
        per_comp = lay_chord ? (1 << mods_in_use()) : (mods_in_use() + 1);
        idx = cur_component * per_comp + 32'(cur_modifier);
        return idx[VB_W-1:0];
    endfunction

    task automatic reset_layout_model();
        lay_num_components = 4'd1;
        lay_num_modifiers  = 3'd0;
        lay_chord          = 1'b0;
        cur_component      = 0;
        cur_modifier       = '0;
        held_slots         = '0;
    endtask

    task automatic expect_vbutton(input logic [VB_W-1:0] vb, input logic st,
                                  input logic last);
        t_result r;
        r.virtual_button  = vb;
        r.virtual_pressed = st;
        r.last_of_run     = last;
        pending_vbuttons = {pending_vbuttons, r};
    endtask

    // virtual button items caused by one button item
    task automatic predict_layer_event(input logic [SLOT_W-1:0] slot, input logic press);
        int unsigned nc;
        int unsigned nm;
        int unsigned mod_idx;
        logic        touch_held;
        nc = comps_in_use();
        nm = mods_in_use();
        if (32'(slot) >= nc + 1 + nm) return;
        held_slots[slot] = press;
        touch_held = held_slots[nc];
        if (32'(slot) < nc) begin
            // selector: only a press moves to another component
            if (press) begin
                expect_vbutton(active_vbutton(), 1'b0, 1'b0);
                cur_component = 32'(slot);
                expect_vbutton(active_vbutton(), touch_held, 1'b1);
            end
        end else if (32'(slot) == nc) begin
            expect_vbutton(active_vbutton(), press, 1'b1);
        end else begin
            mod_idx = 32'(slot) - nc - 1;
            expect_vbutton(active_vbutton(), 1'b0, 1'b0);
            if (lay_chord) begin
                cur_modifier[mod_idx] = press;
            end else if (press) begin
                // lowest pressed modifier wins
                if (cur_modifier == 0 || 32'(cur_modifier) > mod_idx + 1)
                    cur_modifier = MV_W'(mod_idx + 1);
            end else begin
                cur_modifier = '0;
                for (int unsigned i = 0; i < nm && cur_modifier == 0; i++) begin
                    if (nc + 1 + i != 32'(slot) && held_slots[nc + 1 + i])
                        cur_modifier = MV_W'(i + 1);
                end
            end
            expect_vbutton(active_vbutton(), touch_held, 1'b1);
        end
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 64;
                recv_stall_pct  = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 64;
            end
            default: begin
                sender_idle_pct = 20;
                recv_stall_pct  = 20;
            end
        endcase
    endtask

    // send one button item, predict its results once accepted
    task automatic push_button_event(input logic [SLOT_W-1:0] slot, input logic press);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_button_slot <= slot;
        i_pressed     <= press;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        items_sent++;
        if (32'(slot) >= layout_slots()) items_ignored++;
        predict_layer_event(slot, press);
    endtask

    // hold the sender until every expected item is out
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_vbuttons.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_layout_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_NUM_COMPONENTS: lay_num_components = data[NCOMP_W-1:0];
            CFG_NUM_MODIFIERS:  lay_num_modifiers  = data[NMOD_W-1:0];
            CFG_CHORD_MODE:     lay_chord          = data[0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_layout(input logic [CFG_DATA_W-1:0] comps,
                              input logic [CFG_DATA_W-1:0] mods,
                              input logic [CFG_DATA_W-1:0] chord);
        write_layout_reg(CFG_NUM_COMPONENTS, comps);
        write_layout_reg(CFG_NUM_MODIFIERS, mods);
        write_layout_reg(CFG_CHORD_MODE, chord);
    endtask

    task automatic note_failure(input string what, input t_result want, input t_result got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("error %0d (%s): expected vb=%0d st=%0b last=%0b, got vb=%0d st=%0b last=%0b",
                     failures, what, want.virtual_button, want.virtual_pressed,
                     want.last_of_run, got.virtual_button, got.virtual_pressed,
                     got.last_of_run);
    endtask

    // compare each accepted result item with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0 && i_stall == 1'b0) begin
            got = {o_virtual_button, o_virtual_pressed, o_last_of_run};
            results_seen++;
            if (pending_vbuttons.size() == 0) begin
                note_failure("no item expected", '0, got);
            end else begin
                want = pending_vbuttons.pop_front();
                if (got !== want) note_failure("field mismatch", want, got);
            end
        end
    end

    // reset layout: one selector, touch, nothing else
    task automatic test_default_layout();
        set_idling(IDLE_NONE);
        push_button_event(4'd1, 1'b1);
        push_button_event(4'd0, 1'b1);
        push_button_event(4'd0, 1'b0);
        push_button_event(4'd15, 1'b1);
        push_button_event(4'd1, 1'b0);
    endtask

    // eight selectors, touch state carried across a switch
    task automatic test_selectors();
        set_layout(4'd8, 4'd0, 4'd0);
        set_idling(IDLE_BOTH);
        push_button_event(4'd8, 1'b1);
        push_button_event(4'd7, 1'b1);
        push_button_event(4'd3, 1'b1);
        push_button_event(4'd3, 1'b0);
        push_button_event(4'd8, 1'b0);
    endtask

    // lowest pressed modifier wins, release falls back to the next one
    task automatic test_modifier_priority();
        set_layout(4'd3, 4'd4, 4'd0);
        set_idling(IDLE_RECEIVER);
        push_button_event(4'd6, 1'b1);
        push_button_event(4'd4, 1'b1);
        push_button_event(4'd7, 1'b1);
        push_button_event(4'd4, 1'b0);
        push_button_event(4'd6, 1'b0);
        push_button_event(4'd7, 1'b0);
    endtask

    // chord mask up to the top virtual button, first slot past the layout
    task automatic test_chord_extremes();
        set_layout(4'd8, 4'd4, 4'd1);
        set_idling(IDLE_SENDER);
        push_button_event(4'd8, 1'b1);
        push_button_event(4'd7, 1'b1);
        push_button_event(4'd9, 1'b1);
        push_button_event(4'd10, 1'b1);
        push_button_event(4'd11, 1'b1);
        push_button_event(4'd12, 1'b1);
        push_button_event(4'd13, 1'b1);
        push_button_event(4'd12, 1'b0);
    endtask

    // clamped register values, unused index, stale component and modifier
    task automatic test_clamp_and_stale();
        set_layout(4'd0, 4'd7, 4'd0);
        set_idling(IDLE_NONE);
        push_button_event(4'd1, 1'b1);
        write_layout_reg(CFG_NUM_COMPONENTS, 4'd15);
        write_layout_reg(CFG_UNUSED, 4'd15);
        push_button_event(4'd8, 1'b0);
        push_button_event(4'd10, 1'b0);
    endtask

    // fixed then random layouts, mostly toggles of slots inside the layout
    task automatic test_random_traffic();
        int unsigned       counted;
        logic [SLOT_W-1:0] slot;
        logic              press;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: set_layout(4'd1, 4'd0, 4'd0);
                1: set_layout(4'd8, 4'd4, 4'd1);
                2: set_layout(4'd15, 4'd7, 4'd0);
                default: set_layout(CFG_DATA_W'($urandom_range(15)),
                                    CFG_DATA_W'($urandom_range(15)),
                                    CFG_DATA_W'($urandom_range(15)));
            endcase
            set_idling(t_idle_mode'(ph % 4));
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 85) begin
                    slot  = SLOT_W'($urandom_range(layout_slots() - 1));
                    press = ($urandom_range(3) != 0) ? !held_slots[slot]
                                                     : 1'($urandom_range(1));
                end else begin
                    slot  = SLOT_W'($urandom_range(SLOTS - 1));
                    press = 1'($urandom_range(1));
                end
                if (32'(slot) < layout_slots()) counted++;
                push_button_event(slot, press);
                // in phase three, pause the sender mid-phase until the output drains
                if (ph == 3 && counted == ITEMS_PER_PHASE / 2) wait_for_results();
            end
        end
    endtask

    initial begin
        reset_layout_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_layout();
        test_selectors();
        test_modifier_priority();
        test_chord_extremes();
        test_clamp_and_stale();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d button items (%0d outside the layout), checked %0d results",
                 items_sent, items_ignored, results_seen);
        $display("over %0d register writes and four idling patterns", cfg_writes);
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
